[design/drive_enable_mode_sequencer_unit_assert.svh]
// assertion macros for the drive enable and mode sequencer
// used by the top level only
`ifndef DRIVE_ENABLE_MODE_SEQUENCER_UNIT_ASSERT_SVH
`define DRIVE_ENABLE_MODE_SEQUENCER_UNIT_ASSERT_SVH

// implication checked every clock edge outside reset
`define DEMS_ASSERT_IMPL(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define DEMS_ASSERT_NEXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

[design/dems_pkg.sv]
// shared types and constants of the drive enable and mode sequencer
// no dependencies
package dems_pkg;

   localparam int Motors = 16;
   localparam int MotorIdWidth = 4;
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [3:0] CW_SHUTDOWN = 4'd6;
   localparam logic [3:0] CW_SWITCH_ON = 4'd7;
   localparam logic [3:0] CW_ENABLE = 4'd15;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0, PH_STOPPED = 3'd1, PH_SWITCHING = 3'd2,
      PH_ENABLING = 3'd3, PH_RUNNING = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      SW_IDLE = 3'd0, SW_SET_MODE = 3'd1, SW_CLEAR = 3'd2, SW_DISABLE = 3'd3,
      SW_ENABLE = 3'd4, SW_OPERATING = 3'd5, SW_DONE = 3'd6, SW_SPARE = 3'd7
   } switch_type;

   typedef enum logic [1:0] {
      REG_CSP = 2'd0, REG_CSV = 2'd1, REG_CST = 2'd2, REG_PVT = 2'd3
   } reg_index_type;

   // classification made by the front part
   typedef enum logic [1:0] {
      CLS_DROP = 2'd0, CLS_NOCOMM = 2'd1, CLS_ACTIVE = 2'd2
   } class_type;

   typedef struct packed {
      logic [3:0] drive_idx;
      logic comm_ok;
      logic [15:0] drive_status;
      logic signed [7:0] reported_mode;
      logic want_enabled;
      logic signed [7:0] want_mode;
      logic signed [31:0] feedback_pos;
      logic signed [31:0] set_pos;
      logic signed [31:0] set_vel;
      logic signed [15:0] set_torque;
      logic signed [31:0] set_kp;
      logic signed [31:0] set_kd;
   } req_type;

   typedef struct packed {
      logic send_valid;
      logic [3:0] ctrl_cmd;
      logic signed [7:0] op_mode_out;
      logic signed [31:0] pos_target;
      logic signed [31:0] vel_target;
      logic signed [15:0] torque_target;
      logic signed [31:0] gain_kp;
      logic signed [31:0] gain_kd;
      logic [2:0] drive_phase;
      logic [2:0] switch_phase;
   } rsp_type;

   // item as classified by the front part
   typedef struct packed {
      class_type cls;
      logic want_off;
      logic want_none;
      logic mode_ok;
      logic sel_vel;
      logic sel_pos;
      logic sel_torque;
      logic sel_pvt;
      req_type req;
   } work_type;

endpackage

[design/dems_front.sv]
// front part: holds the mode code registers, classifies each item
// depends on dems_pkg
module dems_front (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   input  dems_pkg::req_type req_data,
   output dems_pkg::work_type work_out
);
   import dems_pkg::*;

   logic [7:0] csp_ff, csv_ff, cst_ff, pvt_ff;
   reg_index_type widx;
   logic wr_en;
   logic [7:0] want;

   assign widx = reg_index_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'b00);

   // mode code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csp_ff <= 8'd8;
         csv_ff <= 8'd9;
         cst_ff <= 8'd10;
         pvt_ff <= 8'd5;
      end else if (wr_en) begin
         case (widx)
            REG_CSP: csp_ff <= csr_pwdata[7:0];
            REG_CSV: csv_ff <= csr_pwdata[7:0];
            REG_CST: cst_ff <= csr_pwdata[7:0];
            REG_PVT: pvt_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (widx)
            REG_CSP: csr_prdata = {24'd0, csp_ff};
            REG_CSV: csr_prdata = {24'd0, csv_ff};
            REG_CST: csr_prdata = {24'd0, cst_ff};
            REG_PVT: csr_prdata = {24'd0, pvt_ff};
            default: csr_prdata = '0;
         endcase
      end
   end

   // classification, priority velocity, position, torque, impedance
   assign want = req_data.want_mode;
   always_comb begin
      work_out = '0;
      work_out.req = req_data;
      if (32'(req_data.drive_idx) >= Motors) work_out.cls = CLS_DROP;
      else if (!req_data.comm_ok) work_out.cls = CLS_NOCOMM;
      else work_out.cls = CLS_ACTIVE;
      work_out.want_off = !req_data.want_enabled;
      work_out.want_none = (want == 8'd0);
      work_out.mode_ok = (req_data.reported_mode == req_data.want_mode);
      work_out.sel_vel = (want == csv_ff);
      work_out.sel_pos = !work_out.sel_vel && (want == csp_ff);
      work_out.sel_torque = !work_out.sel_vel && !work_out.sel_pos && (want == cst_ff);
      work_out.sel_pvt = !work_out.sel_vel && !work_out.sel_pos && !work_out.sel_torque
                         && (want == pvt_ff);
   end

endmodule

[design/dems_queue.sv]
// short queue of classified items between front and back
// depends on dems_pkg
module dems_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  dems_pkg::work_type push_data,
   output logic full,
   input  logic pop,
   output dems_pkg::work_type pop_data,
   output logic empty
);
   import dems_pkg::*;

   work_type mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QueueCntWidth-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == QueueCntWidth'(QueueDepth));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (do_push) wp_in = (wp_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wp_ff + 1'b1;
      if (do_pop) rp_in = (rp_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + QueueCntWidth'(do_push) - QueueCntWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= push_data;
   end

endmodule

[design/dems_back.sv]
// back part: per-drive state update and result register
// depends on dems_pkg
module dems_back (
   input  logic clock,
   input  logic reset,
   input  logic work_valid,
   input  dems_pkg::work_type work_in,
   output logic work_take,
   output logic rsp_empty,
   input  logic rsp_pop,
   output dems_pkg::rsp_type rsp_data
);
   import dems_pkg::*;

   phase_type phase_ff [Motors];
   switch_type switch_ff [Motors];
   logic [31:0] hpos_ff [Motors];
   logic [31:0] hvel_ff [Motors];
   logic [15:0] htor_ff [Motors];
   logic [31:0] hkp_ff [Motors];
   logic [31:0] hkd_ff [Motors];

   logic out_valid_ff;
   rsp_type out_ff, out_in;
   logic [MotorIdWidth-1:0] m;
   phase_type ph_cur, ph_in;
   switch_type sw_cur, sw_in;
   logic [31:0] pos_in, vel_in, kp_in, kd_in;
   logic [15:0] tor_in;
   logic [3:0] cw;
   logic [7:0] op;
   logic rdy, son, oen, ok, upd;

   assign work_take = work_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;
   assign m = work_in.req.drive_idx;
   assign ph_cur = phase_ff[m];
   assign sw_cur = switch_ff[m];
   assign rdy = work_in.req.drive_status[0];
   assign son = work_in.req.drive_status[1];
   assign oen = work_in.req.drive_status[2];
   assign ok = work_in.mode_ok;

   // next state of the addressed drive
   always_comb begin
      ph_in = ph_cur;
      sw_in = sw_cur;
      pos_in = hpos_ff[m];
      vel_in = hvel_ff[m];
      tor_in = htor_ff[m];
      kp_in = hkp_ff[m];
      kd_in = hkd_ff[m];
      cw = CW_SHUTDOWN;
      op = work_in.req.want_mode;
      upd = (work_in.cls == CLS_ACTIVE);
      if (work_in.want_off || work_in.want_none || !ok || sw_cur != SW_IDLE
          || !oen) begin
         pos_in = work_in.req.feedback_pos;
         vel_in = '0;
         tor_in = '0;
         kp_in = '0;
         kd_in = '0;
      end
      if (work_in.want_off) begin
         ph_in = PH_STOPPED;
         sw_in = SW_IDLE;
      end else if (work_in.want_none) begin
         ph_in = PH_IDLE;
         sw_in = SW_IDLE;
         op = '0;
      end else if (!ok || sw_cur != SW_IDLE) begin
         ph_in = PH_SWITCHING;
         case (sw_cur)
            SW_IDLE: sw_in = SW_SET_MODE;
            SW_SET_MODE: sw_in = ok ? SW_CLEAR : SW_SET_MODE;
            SW_CLEAR: sw_in = ok ? SW_DISABLE : SW_SET_MODE;
            SW_DISABLE: begin
               if (!ok) sw_in = SW_SET_MODE;
               else sw_in = (rdy && !son && !oen) ? SW_ENABLE : SW_DISABLE;
            end
            SW_ENABLE: begin
               cw = CW_SWITCH_ON;
               if (!ok) sw_in = SW_SET_MODE;
               else if (son && !oen) sw_in = SW_OPERATING;
               else if (!rdy) sw_in = SW_DISABLE;
               else sw_in = SW_ENABLE;
            end
            SW_OPERATING: begin
               cw = CW_ENABLE;
               if (!ok) sw_in = SW_SET_MODE;
               else if (oen) sw_in = SW_DONE;
               else if (!son) sw_in = SW_ENABLE;
               else sw_in = SW_OPERATING;
            end
            default: begin
               cw = CW_ENABLE;
               if (ok && oen) begin
                  ph_in = PH_RUNNING;
                  sw_in = SW_IDLE;
               end else sw_in = ok ? SW_OPERATING : SW_SET_MODE;
            end
         endcase
      end else begin
         if (!son && !rdy) cw = CW_SHUTDOWN;
         else if (!son) cw = CW_SWITCH_ON;
         else cw = CW_ENABLE;
         if (oen) begin
            ph_in = PH_RUNNING;
            kp_in = '0;
            kd_in = '0;
            if (work_in.sel_vel) vel_in = work_in.req.set_vel;
            else if (work_in.sel_pos) pos_in = work_in.req.set_pos;
            else if (work_in.sel_torque) tor_in = work_in.req.set_torque;
            else if (work_in.sel_pvt) begin
               pos_in = work_in.req.set_pos;
               vel_in = work_in.req.set_vel;
               tor_in = work_in.req.set_torque;
               kp_in = work_in.req.set_kp;
               kd_in = work_in.req.set_kd;
            end
         end else ph_in = PH_ENABLING;
      end
   end

   // result from new state; current phases if no comm
   always_comb begin
      out_in = '0;
      case (work_in.cls)
         CLS_ACTIVE: begin
            out_in.send_valid = 1'b1;
            out_in.ctrl_cmd = cw;
            out_in.op_mode_out = op;
            out_in.pos_target = pos_in;
            out_in.vel_target = vel_in;
            out_in.torque_target = tor_in;
            out_in.gain_kp = kp_in;
            out_in.gain_kd = kd_in;
            out_in.drive_phase = ph_in;
            out_in.switch_phase = sw_in;
         end
         CLS_NOCOMM: begin
            out_in.drive_phase = ph_cur;
            out_in.switch_phase = sw_cur;
         end
         default: out_in = '0;
      endcase
   end

   // per-drive phase state and held targets and gains
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Motors; i++) begin
            phase_ff[i] <= PH_IDLE;
            switch_ff[i] <= SW_IDLE;
            hpos_ff[i] <= '0;
            hvel_ff[i] <= '0;
            htor_ff[i] <= '0;
            hkp_ff[i] <= '0;
            hkd_ff[i] <= '0;
         end
      end else if (work_take && upd) begin
         phase_ff[m] <= ph_in;
         switch_ff[m] <= sw_in;
         hpos_ff[m] <= pos_in;
         hvel_ff[m] <= vel_in;
         htor_ff[m] <= tor_in;
         hkp_ff[m] <= kp_in;
         hkd_ff[m] <= kd_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (work_take) out_valid_ff <= 1'b1;
      else if (rsp_pop) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (work_take) out_ff <= out_in;
   end

endmodule

[design/drive_enable_mode_sequencer_unit.sv]
// top level of the drive enable and mode sequencer
// depends on dems_pkg, dems_front, dems_queue, dems_back and the assert header

// One item per clock sustained while results are popped as they appear. An item is
// classified in the front part in its accept cycle and written into a two-entry
// queue; the back part then takes it when the result register is free or being
// popped, reads and writes the addressed drive's state and loads the result
// register, from which the result reaches the result ports. The read-modify-write
// of per-drive state in the back part sets the rate.
`include "drive_enable_mode_sequencer_unit_assert.svh"

module drive_enable_mode_sequencer_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  dems_pkg::req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output dems_pkg::rsp_type rsp_data,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import dems_pkg::*;

   work_type fw, bw;
   logic q_full, q_pop, q_empty;
   logic ctrl_legal;

   assign csr_pready = 1'b1;
   assign req_full = q_full;

   // classify
   dems_front u_front (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .req_data(req_data), .work_out(fw)
   );

   // decoupling queue
   dems_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_push), .push_data(fw), .full(q_full),
      .pop(q_pop), .pop_data(bw), .empty(q_empty)
   );

   // execute
   dems_back u_back (
      .clock(clock), .reset(reset),
      .work_valid(!q_empty), .work_in(bw), .work_take(q_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   // legal command codes
   assign ctrl_legal = (rsp_data.ctrl_cmd == CW_SHUTDOWN)
                       || (rsp_data.ctrl_cmd == CW_SWITCH_ON)
                       || (rsp_data.ctrl_cmd == CW_ENABLE);

   `DEMS_ASSERT_IMPL(a_take_needs_item, q_pop, !q_empty, "back took from empty queue")
   `DEMS_ASSERT_NEXT(a_take_fills_out, q_pop, !rsp_empty, "result missing after take")
   `DEMS_ASSERT_IMPL(a_send_ctrl, !rsp_empty && rsp_data.send_valid, ctrl_legal, "bad cmd")

endmodule
